@@ rtl/rnea_pkg.sv @@
// shared types and constants of the ring neighbour exclusion arbiter
// used by rnea_ctrl, rnea_datapath and the top level; depends on nothing

package rnea_pkg;

    // ring size and derived widths
    localparam int MAX_CLIENTS = 16;
    localparam int CLIENT_W    = $clog2(MAX_CLIENTS);
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
    localparam int COUNT_WIDTH = 16;
    localparam int TICK_W      = 32;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_COUNT_W = 5;
    localparam int QUOTA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARVE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAL_QUOTA   = 2'd2;

    localparam logic [CFG_COUNT_W-1:0] RST_CLIENT_COUNT = 5'd5;
    localparam logic [TICK_W-1:0]      RST_STARVE_LIMIT = 32'd800;
    localparam logic [QUOTA_W-1:0]     RST_MEAL_QUOTA   = 16'd0;

    // item opcodes
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

    // per-client mode
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_IDLE   = 2'd0;
    localparam mode_t MODE_HUNGRY = 2'd1;
    localparam mode_t MODE_BUSY   = 2'd2;

    // halt reason
    localparam int STOP_W = 2;
    localparam logic [STOP_W-1:0] STOP_RUN     = 2'd0;
    localparam logic [STOP_W-1:0] STOP_STARVE  = 2'd1;
    localparam logic [STOP_W-1:0] STOP_QUOTA   = 2'd2;

    // which client a grant attempt looks at
    typedef logic [1:0] try_sel_t;
    localparam try_sel_t SEL_SELF  = 2'd0;
    localparam try_sel_t SEL_LEFT  = 2'd1;
    localparam try_sel_t SEL_RIGHT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     exec;
        logic     try_en;
        try_sel_t try_sel;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hungry_set;
        logic freed;
    } ctrl_sts_t;

endpackage

@@ rtl/rnea_ctrl.sv @@
// sequencing state machine of the ring neighbour exclusion arbiter
// depends on rnea_pkg for the command and status structs

module rnea_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rnea_pkg::ctrl_sts_t sts,
    output rnea_pkg::ctrl_cmd_t cmd,
    output logic                busy,
    output logic                done
);
    import rnea_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EXEC      = 3'd1;
    localparam logic [2:0] S_TRY_SELF  = 3'd2;
    localparam logic [2:0] S_TRY_LEFT  = 3'd3;
    localparam logic [2:0] S_TRY_RIGHT = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.try_sel = SEL_SELF;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.hungry_set)
                begin
                    state_next = S_TRY_SELF;
                end
                else if (sts.freed)
                begin
                    state_next = S_TRY_LEFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TRY_SELF:
            begin
                cmd.try_en = 1'b1;
                state_next = S_DONE;
            end
            S_TRY_LEFT:
            begin
                cmd.try_en  = 1'b1;
                cmd.try_sel = SEL_LEFT;
                state_next  = S_TRY_RIGHT;
            end
            S_TRY_RIGHT:
            begin
                cmd.try_en  = 1'b1;
                cmd.try_sel = SEL_RIGHT;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    // result strobe is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // an accepted start always leaves idle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted start did not enter execution");

endmodule

@@ rtl/rnea_datapath.sv @@
// client state, configuration registers and grant logic of the arbiter
// depends on rnea_pkg; driven by rnea_ctrl through ctrl_cmd_t

module rnea_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rnea_pkg::ctrl_cmd_t                  cmd,
    output rnea_pkg::ctrl_sts_t                  sts,
    input  logic [rnea_pkg::OP_W-1:0]            op,
    input  logic [rnea_pkg::CLIENT_W-1:0]        client,
    input  logic                                 cfg_we,
    input  logic [rnea_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rnea_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [rnea_pkg::MAX_CLIENTS-1:0]     grant_mask,
    output logic [rnea_pkg::MAX_CLIENTS-1:0]     busy_mask,
    output logic [rnea_pkg::STOP_W-1:0]          stop_cause,
    output logic [rnea_pkg::CLIENT_W-1:0]        starved_client
);
    import rnea_pkg::*;

    // configuration
    logic [CFG_COUNT_W-1:0] count_reg;
    logic [TICK_W-1:0]      limit_reg;
    logic [QUOTA_W-1:0]     quota_reg;

    // item latched at start
    logic [OP_W-1:0]        op_reg;
    logic [CLIENT_W-1:0]    client_reg;

    // client state
    mode_t                  mode_reg  [MAX_CLIENTS];
    logic [TICK_W-1:0]      ticks_reg [MAX_CLIENTS];
    logic [COUNT_WIDTH-1:0] uses_reg  [MAX_CLIENTS];
    logic [STOP_W-1:0]      halt_reg;
    logic [CLIENT_W-1:0]    starved_reg;
    logic [MAX_CLIENTS-1:0] grant_reg;

    logic [CNT_W-1:0]       ring_n;
    logic [CLIENT_W-1:0]    last_idx;
    logic                   client_ok;
    logic [CLIENT_W-1:0]    left_c;
    logic [CLIENT_W-1:0]    right_c;
    logic [CLIENT_W-1:0]    target;
    mode_t                  tgt_mode;
    logic [MAX_CLIENTS-1:0] in_ring;
    logic [MAX_CLIENTS-1:0] busy_vec;
    logic [MAX_CLIENTS-1:0] left_busy;
    logic [MAX_CLIENTS-1:0] right_busy;
    logic [MAX_CLIENTS-1:0] nb_free;
    logic                   running;
    logic                   req_take;
    logic                   rel_take;
    logic                   do_grant;
    logic [COUNT_WIDTH-1:0] uses_inc;
    logic                   all_met;
    logic [MAX_CLIENTS-1:0] starve_vec;
    logic [CLIENT_W-1:0]    starve_idx;

    // effective ring size: zero acts as one, clipped to the maximum
    always_comb
    begin
        if (count_reg == '0)
        begin
            ring_n = CNT_W'(1);
        end
        else if (32'(count_reg) > MAX_CLIENTS)
        begin
            ring_n = CNT_W'(MAX_CLIENTS);
        end
        else
        begin
            ring_n = CNT_W'(count_reg);
        end
    end

    assign last_idx  = CLIENT_W'(ring_n - CNT_W'(1));
    assign client_ok = (CNT_W'(client_reg) < ring_n);
    assign left_c    = (client_reg == '0) ? last_idx : client_reg - CLIENT_W'(1);
    assign right_c   = (client_reg == last_idx) ? '0 : client_reg + CLIENT_W'(1);

    always_comb
    begin
        case (cmd.try_sel)
            SEL_LEFT:  target = left_c;
            SEL_RIGHT: target = right_c;
            default:   target = client_reg;
        endcase
    end

    assign tgt_mode = mode_reg[target];

    // per-lane neighbour view, wrapping at the ring size
    always_comb
    begin
        for (int i = 0; i < MAX_CLIENTS; i++)
        begin
            busy_vec[i] = (mode_reg[i] == MODE_BUSY);
            in_ring[i]  = (CNT_W'(i) < ring_n);
        end
        left_busy            = busy_vec << 1;
        left_busy[0]         = busy_vec[last_idx];
        right_busy           = busy_vec >> 1;
        right_busy[last_idx] = busy_vec[0];
        nb_free              = ~(left_busy | right_busy);
    end

    assign running  = (halt_reg == STOP_RUN);
    assign req_take = running && (op_reg == OP_REQUEST) && client_ok
                      && (tgt_mode == MODE_IDLE);
    assign rel_take = running && (op_reg == OP_RELEASE) && client_ok
                      && (tgt_mode == MODE_BUSY);
    assign do_grant = cmd.try_en && (tgt_mode == MODE_HUNGRY) && nb_free[target];

    // saturating use count of the releasing client and the quota check
    always_comb
    begin
        logic [COUNT_WIDTH-1:0] val;
        uses_inc = (uses_reg[client_reg] == '1) ? uses_reg[client_reg]
                   : uses_reg[client_reg] + COUNT_WIDTH'(1);
        all_met  = (quota_reg != '0);
        for (int i = 0; i < MAX_CLIENTS; i++)
        begin
            val = (CLIENT_W'(i) == client_reg) ? uses_inc : uses_reg[i];
            if (in_ring[i] && (32'(val) < 32'(quota_reg)))
            begin
                all_met = 1'b0;
            end
        end
    end

    // a client in the ring starves on a tick when its old age reaches the limit, unless the limit is all ones
    always_comb
    begin
        starve_idx = '0;
        for (int i = 0; i < MAX_CLIENTS; i++)
        begin
            starve_vec[i] = in_ring[i] && (ticks_reg[i] >= limit_reg)
                            && (limit_reg != '1);
        end
        for (int i = MAX_CLIENTS - 1; i >= 0; i--)
        begin
            if (starve_vec[i])
            begin
                starve_idx = CLIENT_W'(i);
            end
        end
    end

    assign sts.hungry_set = cmd.exec && req_take;
    assign sts.freed      = cmd.exec && rel_take && !all_met;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= RST_CLIENT_COUNT;
            limit_reg   <= RST_STARVE_LIMIT;
            quota_reg   <= RST_MEAL_QUOTA;
            halt_reg    <= STOP_RUN;
            starved_reg <= '0;
            for (int i = 0; i < MAX_CLIENTS; i++)
            begin
                mode_reg[i]  <= MODE_IDLE;
                ticks_reg[i] <= '0;
                uses_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLIENT_COUNT: count_reg <= cfg_data[CFG_COUNT_W-1:0];
                    CFG_STARVE_LIMIT: limit_reg <= cfg_data[TICK_W-1:0];
                    CFG_MEAL_QUOTA:   quota_reg <= cfg_data[QUOTA_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.exec && running)
            begin
                unique case (op_reg)
                    OP_REQUEST:
                    begin
                        if (req_take)
                        begin
                            mode_reg[client_reg] <= MODE_HUNGRY;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (rel_take)
                        begin
                            uses_reg[client_reg] <= uses_inc;
                            if (all_met)
                            begin
                                halt_reg <= STOP_QUOTA;
                            end
                            else
                            begin
                                mode_reg[client_reg] <= MODE_IDLE;
                            end
                        end
                    end
                    OP_TICK:
                    begin
                        for (int i = 0; i < MAX_CLIENTS; i++)
                        begin
                            if (in_ring[i] && (ticks_reg[i] != '1))
                            begin
                                ticks_reg[i] <= ticks_reg[i] + TICK_W'(1);
                            end
                        end
                        if (starve_vec != '0)
                        begin
                            halt_reg    <= STOP_STARVE;
                            starved_reg <= starve_idx;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (do_grant)
            begin
                mode_reg[target]  <= MODE_BUSY;
                ticks_reg[target] <= '0;
            end
        end
    end

    // item payload and grant collection
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            client_reg <= client;
            grant_reg  <= '0;
        end
        else if (do_grant)
        begin
            grant_reg[target] <= 1'b1;
        end
    end

    assign grant_mask     = grant_reg;
    assign busy_mask      = busy_vec;
    assign stop_cause     = halt_reg;
    assign starved_client = (halt_reg == STOP_STARVE) ? starved_reg : '0;

    // a halt lasts until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (halt_reg != STOP_RUN) |=> (halt_reg == $past(halt_reg)))
        else $error("halt reason changed after halting");

    // starved index is only ever set together with a starvation halt
    a_starved_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (halt_reg != STOP_STARVE) |-> (starved_reg == '0))
        else $error("starved index set without starvation halt");

endmodule

@@ rtl/ring_neighbor_exclusion_arbiter_top.sv @@
// top level of the ring neighbour exclusion arbiter
// instantiates rnea_ctrl and rnea_datapath; depends on rnea_pkg

// Clients sit on a ring and each one needs both resources it shares with
// its neighbours. An item is taken when start is high and busy is low; op
// selects request, release or time tick for the given client. Every item
// gives exactly one result, shown for a single cycle with done high; the
// receiver cannot stall it, so it must take the beat in that cycle. The
// item runs through an execute step and then one grant attempt per client
// to re-check, sequenced by the controller: a tick, an ignored item, a
// release that halts on the quota or any item while halted goes from
// execute straight to done, a request through its own attempt, and a
// release that frees its client through left then right attempts in turn.
// busy stays high until the cycle after done, so items never overlap. A
// starvation or quota halt freezes all client state until reset; results
// then still show busy_mask, stop_cause and starved_client. Configuration
// writes go through cfg_valid/cfg_ready with cfg_index selecting client
// count (0), starvation limit (1) or meal quota (2); cfg_ready is low
// while an item is in flight or offered on start, and writes to index 3
// are dropped.

module ring_neighbor_exclusion_arbiter_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // item channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic [rnea_pkg::OP_W-1:0]            op,
    input  logic [rnea_pkg::CLIENT_W-1:0]        client,
    // result channel
    output logic                                 done,
    output logic [rnea_pkg::MAX_CLIENTS-1:0]     grant_mask,
    output logic [rnea_pkg::MAX_CLIENTS-1:0]     busy_mask,
    output logic [rnea_pkg::STOP_W-1:0]          stop_cause,
    output logic [rnea_pkg::CLIENT_W-1:0]        starved_client,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rnea_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rnea_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rnea_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      cfg_we;

    // configuration only lands while no item is in flight or being taken
    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid && cfg_ready;

    rnea_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    rnea_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .op             (op),
        .client         (client),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .grant_mask     (grant_mask),
        .busy_mask      (busy_mask),
        .stop_cause     (stop_cause),
        .starved_client (starved_client)
    );

    // every client granted by the item is still busy when the beat goes out
    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((grant_mask & ~busy_mask) == '0))
        else $error("granted client not busy at result");

    // the result beat belongs to an item still in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy && !cfg_ready))
        else $error("result strobe outside an item");

endmodule
